[rtl/core/rvd_pkg.sv]
// package with operation codes, opcode and register index constants for the rv32ima decoder
package rvd_pkg;

  // decoded operation numbers, zero marks an illegal word
  typedef enum logic [6:0] {
    OP_ILLEGAL     = 7'd0,
    OP_LB          = 7'd1,
    OP_LH          = 7'd2,
    OP_LW          = 7'd3,
    OP_LBU         = 7'd4,
    OP_LHU         = 7'd5,
    OP_SB          = 7'd6,
    OP_SH          = 7'd7,
    OP_SW          = 7'd8,
    OP_FENCE       = 7'd9,
    OP_ADDI        = 7'd10,
    OP_SLTI        = 7'd11,
    OP_SLTIU       = 7'd12,
    OP_XORI        = 7'd13,
    OP_ORI         = 7'd14,
    OP_ANDI        = 7'd15,
    OP_SLLI        = 7'd16,
    OP_SRLI        = 7'd17,
    OP_SRAI        = 7'd18,
    OP_LUI         = 7'd19,
    OP_AUIPC       = 7'd20,
    OP_ADD         = 7'd21,
    OP_SUB         = 7'd22,
    OP_SLL         = 7'd23,
    OP_SLT         = 7'd24,
    OP_SLTU        = 7'd25,
    OP_XOR         = 7'd26,
    OP_SRL         = 7'd27,
    OP_SRA         = 7'd28,
    OP_OR          = 7'd29,
    OP_AND         = 7'd30,
    OP_MUL         = 7'd31,
    OP_MULH        = 7'd32,
    OP_MULHSU      = 7'd33,
    OP_MULHU       = 7'd34,
    OP_DIV         = 7'd35,
    OP_DIVU        = 7'd36,
    OP_REM         = 7'd37,
    OP_REMU        = 7'd38,
    OP_LR_W        = 7'd39,
    OP_SC_W        = 7'd40,
    OP_AMOSWAP_W   = 7'd41,
    OP_AMOADD_W    = 7'd42,
    OP_AMOXOR_W    = 7'd43,
    OP_AMOAND_W    = 7'd44,
    OP_AMOOR_W     = 7'd45,
    OP_AMOMIN_W    = 7'd46,
    OP_AMOMAX_W    = 7'd47,
    OP_AMOMINU_W   = 7'd48,
    OP_AMOMAXU_W   = 7'd49,
    OP_BEQ         = 7'd50,
    OP_BNE         = 7'd51,
    OP_BLT         = 7'd52,
    OP_BGE         = 7'd53,
    OP_BLTU        = 7'd54,
    OP_BGEU        = 7'd55,
    OP_JAL         = 7'd56,
    OP_JALR        = 7'd57,
    OP_CSRRW       = 7'd58,
    OP_CSRRS       = 7'd59,
    OP_CSRRC       = 7'd60,
    OP_CSRRWI      = 7'd61,
    OP_CSRRSI      = 7'd62,
    OP_CSRRCI      = 7'd63,
    OP_ECALL       = 7'd64,
    OP_EBREAK      = 7'd65,
    OP_SRET        = 7'd66,
    OP_MRET        = 7'd67,
    OP_WFI         = 7'd68,
    OP_HALT        = 7'd69,
    OP_DUMPREGS    = 7'd70,
    OP_TRACESET    = 7'd71,
    OP_TRACERST    = 7'd72,
    OP_CSRDUMP     = 7'd73,
    OP_SFENCE_VMA  = 7'd74
  } op_e;

  localparam logic [6:0] OpLast = 7'd74;

  // major opcodes
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_AMO      = 7'h2F;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  // funct7 values
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_SFENCE = 7'h09;

  // amo funct5 values
  localparam logic [4:0] F5_LR      = 5'h02;
  localparam logic [4:0] F5_SC      = 5'h03;
  localparam logic [4:0] F5_AMOSWAP = 5'h01;
  localparam logic [4:0] F5_AMOADD  = 5'h00;
  localparam logic [4:0] F5_AMOXOR  = 5'h04;
  localparam logic [4:0] F5_AMOAND  = 5'h0C;
  localparam logic [4:0] F5_AMOOR   = 5'h08;
  localparam logic [4:0] F5_AMOMIN  = 5'h10;
  localparam logic [4:0] F5_AMOMAX  = 5'h14;
  localparam logic [4:0] F5_AMOMINU = 5'h18;
  localparam logic [4:0] F5_AMOMAXU = 5'h1C;

  // standard system immediates
  localparam logic [11:0] IMM_ECALL  = 12'h000;
  localparam logic [11:0] IMM_EBREAK = 12'h001;
  localparam logic [11:0] IMM_SRET   = 12'h102;
  localparam logic [11:0] IMM_MRET   = 12'h302;
  localparam logic [11:0] IMM_WFI    = 12'h105;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] CFG_CUSTOM_EN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ILLEGAL_NOP = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HALT        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DUMP_REGS   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TRACE_SET   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TRACE_RST   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CSR_DUMP    = 3'd6;

  // configuration seen by the decode logic
  typedef struct packed {
    logic        custom_en;
    logic [11:0] halt_code;
    logic [11:0] dump_regs_code;
    logic [11:0] trace_set_code;
    logic [11:0] trace_reset_code;
    logic [11:0] csr_dump_code;
  } dec_cfg_t;

endpackage

[rtl/core/rvd_decode.sv]
// combinational classification of one rv32ima instruction word
module rvd_decode
  import rvd_pkg::*;
(
  input  logic [31:0] instr_i,
  input  dec_cfg_t    cfg_i,
  output op_e         op_o
);

  logic [6:0]  opcode;
  logic [2:0]  funct3;
  logic [6:0]  funct7;
  logic [4:0]  funct5;
  logic [4:0]  rs2;
  logic [11:0] imm12;
  op_e         priv_op;
  op_e         custom_op;

  assign opcode = instr_i[6:0];
  assign funct3 = instr_i[14:12];
  assign funct7 = instr_i[31:25];
  assign funct5 = instr_i[31:27];
  assign rs2    = instr_i[24:20];
  assign imm12  = instr_i[31:20];

  // simulator-specific system codes, first match wins
  always_comb begin
    custom_op = OP_ILLEGAL;
    if (imm12 == cfg_i.halt_code) begin
      custom_op = OP_HALT;
    end else if (imm12 == cfg_i.dump_regs_code) begin
      custom_op = OP_DUMPREGS;
    end else if (imm12 == cfg_i.trace_set_code) begin
      custom_op = OP_TRACESET;
    end else if (imm12 == cfg_i.trace_reset_code) begin
      custom_op = OP_TRACERST;
    end else if (imm12 == cfg_i.csr_dump_code) begin
      custom_op = OP_CSRDUMP;
    end
    if (!cfg_i.custom_en) begin
      custom_op = OP_ILLEGAL;
    end
  end

  // privileged system ops, sfence.vma first, then standard immediates
  always_comb begin
    if (funct7 == F7_SFENCE) begin
      priv_op = OP_SFENCE_VMA;
    end else begin
      unique case (imm12)
        IMM_ECALL:  priv_op = OP_ECALL;
        IMM_EBREAK: priv_op = OP_EBREAK;
        IMM_SRET:   priv_op = OP_SRET;
        IMM_MRET:   priv_op = OP_MRET;
        IMM_WFI:    priv_op = OP_WFI;
        default:    priv_op = custom_op;
      endcase
    end
  end

  // main opcode decode
  always_comb begin
    op_o = OP_ILLEGAL;
    unique case (opcode)
      OPC_LOAD: begin
        unique case (funct3)
          3'd0:    op_o = OP_LB;
          3'd1:    op_o = OP_LH;
          3'd2:    op_o = OP_LW;
          3'd4:    op_o = OP_LBU;
          3'd5:    op_o = OP_LHU;
          default: op_o = OP_ILLEGAL;
        endcase
      end
      OPC_MISC_MEM: op_o = (funct3 == 3'd0) ? OP_FENCE : OP_ILLEGAL;
      OPC_OP_IMM: begin
        unique case (funct3)
          3'd0:    op_o = OP_ADDI;
          3'd1:    op_o = (funct7 == F7_BASE) ? OP_SLLI : OP_ILLEGAL;
          3'd2:    op_o = OP_SLTI;
          3'd3:    op_o = OP_SLTIU;
          3'd4:    op_o = OP_XORI;
          3'd5: begin
            if (funct7 == F7_BASE) begin
              op_o = OP_SRLI;
            end else if (funct7 == F7_ALT) begin
              op_o = OP_SRAI;
            end
          end
          3'd6:    op_o = OP_ORI;
          default: op_o = OP_ANDI;
        endcase
      end
      OPC_AUIPC: op_o = OP_AUIPC;
      OPC_STORE: begin
        unique case (funct3)
          3'd0:    op_o = OP_SB;
          3'd1:    op_o = OP_SH;
          3'd2:    op_o = OP_SW;
          default: op_o = OP_ILLEGAL;
        endcase
      end
      OPC_AMO: begin
        if (funct3 == 3'd2) begin
          unique case (funct5)
            F5_LR:      op_o = (rs2 == 5'd0) ? OP_LR_W : OP_ILLEGAL;
            F5_SC:      op_o = OP_SC_W;
            F5_AMOSWAP: op_o = OP_AMOSWAP_W;
            F5_AMOADD:  op_o = OP_AMOADD_W;
            F5_AMOXOR:  op_o = OP_AMOXOR_W;
            F5_AMOAND:  op_o = OP_AMOAND_W;
            F5_AMOOR:   op_o = OP_AMOOR_W;
            F5_AMOMIN:  op_o = OP_AMOMIN_W;
            F5_AMOMAX:  op_o = OP_AMOMAX_W;
            F5_AMOMINU: op_o = OP_AMOMINU_W;
            F5_AMOMAXU: op_o = OP_AMOMAXU_W;
            default:    op_o = OP_ILLEGAL;
          endcase
        end
      end
      OPC_OP: begin
        if (funct7 == F7_BASE) begin
          unique case (funct3)
            3'd0:    op_o = OP_ADD;
            3'd1:    op_o = OP_SLL;
            3'd2:    op_o = OP_SLT;
            3'd3:    op_o = OP_SLTU;
            3'd4:    op_o = OP_XOR;
            3'd5:    op_o = OP_SRL;
            3'd6:    op_o = OP_OR;
            default: op_o = OP_AND;
          endcase
        end else if (funct7 == F7_MULDIV) begin
          unique case (funct3)
            3'd0:    op_o = OP_MUL;
            3'd1:    op_o = OP_MULH;
            3'd2:    op_o = OP_MULHSU;
            3'd3:    op_o = OP_MULHU;
            3'd4:    op_o = OP_DIV;
            3'd5:    op_o = OP_DIVU;
            3'd6:    op_o = OP_REM;
            default: op_o = OP_REMU;
          endcase
        end else if (funct7 == F7_ALT) begin
          if (funct3 == 3'd0) begin
            op_o = OP_SUB;
          end else if (funct3 == 3'd5) begin
            op_o = OP_SRA;
          end
        end
      end
      OPC_LUI: op_o = OP_LUI;
      OPC_BRANCH: begin
        unique case (funct3)
          3'd0:    op_o = OP_BEQ;
          3'd1:    op_o = OP_BNE;
          3'd4:    op_o = OP_BLT;
          3'd5:    op_o = OP_BGE;
          3'd6:    op_o = OP_BLTU;
          3'd7:    op_o = OP_BGEU;
          default: op_o = OP_ILLEGAL;
        endcase
      end
      OPC_JALR: op_o = (funct3 == 3'd0) ? OP_JALR : OP_ILLEGAL;
      OPC_JAL:  op_o = OP_JAL;
      OPC_SYSTEM: begin
        unique case (funct3)
          3'd0:    op_o = priv_op;
          3'd1:    op_o = OP_CSRRW;
          3'd2:    op_o = OP_CSRRS;
          3'd3:    op_o = OP_CSRRC;
          3'd5:    op_o = OP_CSRRWI;
          3'd6:    op_o = OP_CSRRSI;
          3'd7:    op_o = OP_CSRRCI;
          default: op_o = OP_ILLEGAL;
        endcase
      end
      default: op_o = OP_ILLEGAL;
    endcase
  end

endmodule

[rtl/core/rv32ima_instruction_decoder_unit.sv]
// top level of the rv32ima instruction decoder: config registers, input and result stages
//
// One instruction word is taken per cycle with start_i (busy_o never rises), and its
// classification appears on operation_o, is_illegal_o and raise_exception_o after the
// input register and the result register, marked by done_o for exactly one cycle. A
// single pass of decode logic lies between those two registers; the sustained rate is
// one transaction per clock. Results cannot be held off by the receiver, so done_o must
// be sampled on the cycle it is high. Configuration writes through cfg_we_i take effect
// on the next clock and should be issued while no transaction is in flight.
module rv32ima_instruction_decoder_unit
  import rvd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [31:0]         instruction_word_i,
  output logic                done_o,
  output logic [6:0]          operation_o,
  output logic                is_illegal_o,
  output logic                raise_exception_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic        custom_en_q;
  logic        illegal_nop_q;
  logic [11:0] halt_code_q;
  logic [11:0] dump_regs_code_q;
  logic [11:0] trace_set_code_q;
  logic [11:0] trace_reset_code_q;
  logic [11:0] csr_dump_code_q;

  logic        in_valid_q;
  logic [31:0] word_q;
  logic        done_q;
  logic [6:0]  op_q;
  logic        illegal_q;
  logic        raise_q;

  dec_cfg_t    dec_cfg;
  op_e         dec_op;
  logic        dec_illegal;

  // decoder never stalls
  assign busy_o = 1'b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      custom_en_q        <= 1'b0;
      illegal_nop_q      <= 1'b0;
      halt_code_q        <= 12'd2244;
      dump_regs_code_q   <= 12'd2245;
      trace_set_code_q   <= 12'd2246;
      trace_reset_code_q <= 12'd2247;
      csr_dump_code_q    <= 12'd2248;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CUSTOM_EN:   custom_en_q        <= cfg_wdata_i[0];
        CFG_ILLEGAL_NOP: illegal_nop_q      <= cfg_wdata_i[0];
        CFG_HALT:        halt_code_q        <= cfg_wdata_i;
        CFG_DUMP_REGS:   dump_regs_code_q   <= cfg_wdata_i;
        CFG_TRACE_SET:   trace_set_code_q   <= cfg_wdata_i;
        CFG_TRACE_RST:   trace_reset_code_q <= cfg_wdata_i;
        CFG_CSR_DUMP:    csr_dump_code_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i & ~busy_o;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (start_i & ~busy_o) begin
      word_q <= instruction_word_i;
    end
  end

  // decode
  assign dec_cfg = '{
    custom_en:        custom_en_q,
    halt_code:        halt_code_q,
    dump_regs_code:   dump_regs_code_q,
    trace_set_code:   trace_set_code_q,
    trace_reset_code: trace_reset_code_q,
    csr_dump_code:    csr_dump_code_q
  };

  rvd_decode u_decode (
    .instr_i (word_q),
    .cfg_i   (dec_cfg),
    .op_o    (dec_op)
  );

  assign dec_illegal = (dec_op == OP_ILLEGAL);

  // result stage strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      op_q      <= dec_op;
      illegal_q <= dec_illegal;
      raise_q   <= dec_illegal & ~illegal_nop_q;
    end
  end

  assign done_o            = done_q;
  assign operation_o       = op_q;
  assign is_illegal_o      = illegal_q;
  assign raise_exception_o = raise_q;

  // every accepted word yields a result strobe on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted transaction produced no result");

  // illegal flag agrees with the operation code
  a_illegal_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_illegal_o == (operation_o == OP_ILLEGAL)))
    else $error("illegal flag disagrees with operation");

  // exception only on illegal words
  a_raise_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && raise_exception_o) |-> is_illegal_o)
    else $error("exception raised on a legal word");

  // operation code within the defined range
  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (operation_o <= OpLast))
    else $error("operation code out of range");

endmodule

[tb/tb_rv32ima_instruction_decoder_unit.sv]
// self-checking testbench for the rv32ima instruction decoder with a decode scoreboard
`timescale 1ns / 100ps

module tb_rv32ima_instruction_decoder_unit;
  import rvd_pkg::*;

  // major opcodes, amo funct5 values and standard system immediates for word building
  localparam logic [6:0] MAJOR_OPCODES [12] = '{
    OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM, OPC_AUIPC, OPC_STORE, OPC_AMO,
    OPC_OP, OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM
  };
  localparam logic [4:0] AMO_FUNCT5 [11] = '{
    F5_LR, F5_SC, F5_AMOSWAP, F5_AMOADD, F5_AMOXOR, F5_AMOAND,
    F5_AMOOR, F5_AMOMIN, F5_AMOMAX, F5_AMOMINU, F5_AMOMAXU
  };
  localparam logic [11:0] PRIV_IMMS [5] = '{
    IMM_ECALL, IMM_EBREAK, IMM_SRET, IMM_MRET, IMM_WFI
  };

  // one decoded classification
  typedef struct packed {
    op_e  op;
    logic illegal;
    logic trap;
  } decode_res_t;

  // decode predictor with its own copy of the configuration
  class decode_scoreboard;
    logic        custom_en;
    logic        illegal_nop;
    logic [11:0] codes [5];
    decode_res_t pending_decodes [$];
    int unsigned errors;

    function new();
      custom_en   = 1'b0;
      illegal_nop = 1'b0;
      codes       = '{12'd2244, 12'd2245, 12'd2246, 12'd2247, 12'd2248};
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_CUSTOM_EN:   custom_en = data[0];
        CFG_ILLEGAL_NOP: illegal_nop = data[0];
        CFG_HALT, CFG_DUMP_REGS, CFG_TRACE_SET, CFG_TRACE_RST, CFG_CSR_DUMP:
          codes[idx - CFG_HALT] = data;
        default: ;
      endcase
    endfunction

    // privileged and simulator-specific system words
    function op_e classify_system(logic [31:0] w);
      op_e op;
      op = OP_ILLEGAL;
      if (w[31:25] == F7_SFENCE) return OP_SFENCE_VMA;
      case (w[31:20])
        IMM_ECALL:  return OP_ECALL;
        IMM_EBREAK: return OP_EBREAK;
        IMM_SRET:   return OP_SRET;
        IMM_MRET:   return OP_MRET;
        IMM_WFI:    return OP_WFI;
        default: ;
      endcase
      // walk backwards so the first matching custom code wins
      for (int i = 4; i >= 0; i--) begin
        if (w[31:20] == codes[i]) op = op_e'(OP_HALT + 7'(i));
      end
      return custom_en ? op : OP_ILLEGAL;
    endfunction

    function op_e classify(logic [31:0] w);
      logic [2:0] f3;
      logic [6:0] f7;
      op_e        op;
      f3 = w[14:12];
      f7 = w[31:25];
      op = OP_ILLEGAL;
      case (w[6:0])
        OPC_LOAD: begin
          case (f3)
            3'd0: op = OP_LB;
            3'd1: op = OP_LH;
            3'd2: op = OP_LW;
            3'd4: op = OP_LBU;
            3'd5: op = OP_LHU;
            default: ;
          endcase
        end
        OPC_MISC_MEM: if (f3 == 3'd0) op = OP_FENCE;
        OPC_OP_IMM: begin
          case (f3)
            3'd0: op = OP_ADDI;
            3'd1: if (f7 == F7_BASE) op = OP_SLLI;
            3'd2: op = OP_SLTI;
            3'd3: op = OP_SLTIU;
            3'd4: op = OP_XORI;
            3'd5: begin
              if (f7 == F7_BASE) op = OP_SRLI;
              else if (f7 == F7_ALT) op = OP_SRAI;
            end
            3'd6: op = OP_ORI;
            default: op = OP_ANDI;
          endcase
        end
        OPC_AUIPC: op = OP_AUIPC;
        OPC_STORE: begin
          case (f3)
            3'd0: op = OP_SB;
            3'd1: op = OP_SH;
            3'd2: op = OP_SW;
            default: ;
          endcase
        end
        OPC_AMO: begin
          if (f3 == 3'd2) begin
            case (w[31:27])
              F5_LR:      if (w[24:20] == 5'd0) op = OP_LR_W;
              F5_SC:      op = OP_SC_W;
              F5_AMOSWAP: op = OP_AMOSWAP_W;
              F5_AMOADD:  op = OP_AMOADD_W;
              F5_AMOXOR:  op = OP_AMOXOR_W;
              F5_AMOAND:  op = OP_AMOAND_W;
              F5_AMOOR:   op = OP_AMOOR_W;
              F5_AMOMIN:  op = OP_AMOMIN_W;
              F5_AMOMAX:  op = OP_AMOMAX_W;
              F5_AMOMINU: op = OP_AMOMINU_W;
              F5_AMOMAXU: op = OP_AMOMAXU_W;
              default: ;
            endcase
          end
        end
        OPC_OP: begin
          if (f7 == F7_BASE) begin
            case (f3)
              3'd0: op = OP_ADD;
              3'd1: op = OP_SLL;
              3'd2: op = OP_SLT;
              3'd3: op = OP_SLTU;
              3'd4: op = OP_XOR;
              3'd5: op = OP_SRL;
              3'd6: op = OP_OR;
              default: op = OP_AND;
            endcase
          end else if (f7 == F7_MULDIV) begin
            // multiply/divide ops are numbered in funct3 order
            op = op_e'(OP_MUL + 7'(f3));
          end else if (f7 == F7_ALT) begin
            if (f3 == 3'd0) op = OP_SUB;
            else if (f3 == 3'd5) op = OP_SRA;
          end
        end
        OPC_LUI: op = OP_LUI;
        OPC_BRANCH: begin
          case (f3)
            3'd0: op = OP_BEQ;
            3'd1: op = OP_BNE;
            3'd4: op = OP_BLT;
            3'd5: op = OP_BGE;
            3'd6: op = OP_BLTU;
            3'd7: op = OP_BGEU;
            default: ;
          endcase
        end
        OPC_JALR: if (f3 == 3'd0) op = OP_JALR;
        OPC_JAL: op = OP_JAL;
        OPC_SYSTEM: begin
          case (f3)
            3'd0: op = classify_system(w);
            3'd1: op = OP_CSRRW;
            3'd2: op = OP_CSRRS;
            3'd3: op = OP_CSRRC;
            3'd5: op = OP_CSRRWI;
            3'd6: op = OP_CSRRSI;
            3'd7: op = OP_CSRRCI;
            default: ;
          endcase
        end
        default: ;
      endcase
      return op;
    endfunction

    // accepted instruction word: queue its classification
    function void note_word(logic [31:0] w);
      decode_res_t res;
      res.op      = classify(w);
      res.illegal = (res.op == OP_ILLEGAL);
      res.trap    = res.illegal && !illegal_nop;
      pending_decodes.push_back(res);
    endfunction

    // result strobe: compare with the oldest queued classification
    function void check_result(logic [6:0] op, logic illegal, logic trap);
      decode_res_t res;
      if (pending_decodes.size() == 0) begin
        $error("unexpected result transaction: operation %0d", op);
        errors++;
        return;
      end
      res = pending_decodes.pop_front();
      if (op !== res.op) begin
        $error("operation: expected %0d, actual %0d", res.op, op);
        errors++;
      end
      if (illegal !== res.illegal) begin
        $error("is_illegal: expected %0b, actual %0b", res.illegal, illegal);
        errors++;
      end
      if (trap !== res.trap) begin
        $error("raise_exception: expected %0b, actual %0b", res.trap, trap);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_decodes.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [31:0]         instruction_word_i;
  logic                done_o;
  logic [6:0]          operation_o;
  logic                is_illegal_o;
  logic                raise_exception_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  decode_scoreboard sb;
  logic             burst;

  rv32ima_instruction_decoder_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .instruction_word_i (instruction_word_i),
    .done_o             (done_o),
    .operation_o        (operation_o),
    .is_illegal_o       (is_illegal_o),
    .raise_exception_o  (raise_exception_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // 2 ns clock
  always #1 clk_i = ~clk_i;

  // monitor: accepted words and result strobes, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_word(instruction_word_i);
      if (done_o) sb.check_result(operation_o, is_illegal_o, raise_exception_o);
    end
  end

  // system word with funct3 zero, random rs1 and rd
  function automatic logic [31:0] sys_word(input logic [11:0] imm);
    return {imm, 5'($urandom), 3'd0, 5'($urandom), OPC_SYSTEM};
  endfunction

  // mostly well-formed words with random content, some pure noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) == 0) return w;
    w[6:0] = MAJOR_OPCODES[$urandom_range(0, 11)];
    case (w[6:0])
      OPC_OP_IMM: begin
        if ($urandom_range(0, 3) != 0) w[31:25] = $urandom_range(0, 1) ? F7_BASE : F7_ALT;
      end
      OPC_OP: begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 2))
            0: w[31:25] = F7_BASE;
            1: w[31:25] = F7_MULDIV;
            default: w[31:25] = F7_ALT;
          endcase
        end
      end
      OPC_AMO: begin
        if ($urandom_range(0, 3) != 0) begin
          w[14:12] = 3'd2;
          w[31:27] = AMO_FUNCT5[$urandom_range(0, 10)];
          if (w[31:27] == F5_LR && $urandom_range(0, 1) == 1) w[24:20] = 5'd0;
        end
      end
      OPC_MISC_MEM, OPC_JALR: begin
        if ($urandom_range(0, 3) != 0) w[14:12] = 3'd0;
      end
      OPC_SYSTEM: begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 3))
            0: w = sys_word(PRIV_IMMS[$urandom_range(0, 4)]);
            1: w = sys_word(sb.codes[$urandom_range(0, 4)]);
            2: w = sys_word(12'($urandom));
            default: begin
              w[14:12] = 3'd0;
              w[31:25] = F7_SFENCE;
            end
          endcase
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // one transaction: optional idle gap, then hold start until accepted
  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start_i            <= 1'b0;
      instruction_word_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start_i            <= 1'b1;
    instruction_word_i <= w;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      send_word(random_word());
    end
    burst = 1'b0;
  endtask

  // stop issuing and wait for outstanding results plus the pipeline latency
  task automatic drain();
    int unsigned waited;
    waited = 0;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // write every register index, the unused one included
  task automatic cfg_write_all(input logic en, input logic nop,
                               input logic [11:0] code_set [5]);
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    for (int i = 0; i < 8; i++) begin
      idx = CfgIdxW'(i);
      if (idx == CFG_CUSTOM_EN) data = {11'($urandom), en};
      else if (idx == CFG_ILLEGAL_NOP) data = {11'($urandom), nop};
      else if (idx > CFG_CSR_DUMP) data = 12'($urandom);
      else data = code_set[idx - CFG_HALT];
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= data;
      @(posedge clk_i);
      sb.write_reg(idx, data);
    end
    cfg_we_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [31:0] directed [$];
    logic [11:0] code_set [5];
    sb                 = new();
    burst              = 1'b0;
    rst_ni             = 1'b0;
    start_i            = 1'b0;
    instruction_word_i = '0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = '0;
    cfg_wdata_i        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: extremes, privileged words, field checks
    directed = '{
      32'h0000_0000, 32'hFFFF_FFFF,
      sys_word(IMM_ECALL), sys_word(IMM_EBREAK), sys_word(IMM_SRET),
      sys_word(IMM_MRET), sys_word(IMM_WFI), sys_word(12'd2244),
      {F7_SFENCE, 5'h1F, 5'h1F, 3'd0, 5'h1F, OPC_SYSTEM},
      {F7_SFENCE, 5'h1F, 5'h1F, 3'd1, 5'h1F, OPC_SYSTEM},
      {12'hFFF, 5'h1F, 3'd4, 5'h1F, OPC_SYSTEM},
      {F5_LR, 2'b11, 5'd0, 5'h1F, 3'd2, 5'h1F, OPC_AMO},
      {F5_LR, 2'b00, 5'd1, 5'h00, 3'd2, 5'h00, OPC_AMO},
      {F5_SC, 2'b11, 5'h1F, 5'h1F, 3'd2, 5'h1F, OPC_AMO},
      {F7_ALT, 5'h1F, 5'h1F, 3'd5, 5'h1F, OPC_OP_IMM},
      {F7_ALT, 5'h1F, 5'h1F, 3'd1, 5'h1F, OPC_OP_IMM},
      {F7_MULDIV, 5'h1F, 5'h1F, 3'd7, 5'h1F, OPC_OP},
      {F7_ALT, 5'h00, 5'h00, 3'd0, 5'h00, OPC_OP},
      {7'h7F, 5'h1F, 5'h1F, 3'd0, 5'h1F, OPC_OP},
      32'hFFFF_FFB7, 32'hFFFF_FFEF
    };
    foreach (directed[i]) send_word(directed[i]);
    send_random(200);

    // custom ops on, illegal words as no-ops
    drain();
    for (int i = 0; i < 5; i++) code_set[i] = 12'($urandom);
    cfg_write_all(1'b1, 1'b1, code_set);
    for (int i = 0; i < 5; i++) send_word(sys_word(sb.codes[i]));
    send_random(250);

    // code collisions: standard immediate, equal customs, sfence range, all ones
    drain();
    code_set = '{IMM_ECALL, 12'hABC, 12'hABC, 12'h123, 12'hFFF};
    cfg_write_all(1'b1, 1'b0, code_set);
    for (int i = 0; i < 5; i++) send_word(sys_word(sb.codes[i]));
    send_word(sys_word(12'h7FF));
    send_random(250);

    // custom ops off with codes at the extremes
    drain();
    code_set = '{12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF};
    cfg_write_all(1'b0, 1'b1, code_set);
    send_word(sys_word(12'hFFF));
    send_random(250);

    // random settings, codes often on standard immediates or the sfence range
    for (int p = 0; p < 3; p++) begin
      drain();
      for (int i = 0; i < 5; i++) begin
        case ($urandom_range(0, 3))
          0: code_set[i] = PRIV_IMMS[$urandom_range(0, 4)];
          1: code_set[i] = {F7_SFENCE, 5'($urandom)};
          default: code_set[i] = 12'($urandom);
        endcase
      end
      cfg_write_all(1'($urandom), 1'($urandom), code_set);
      send_random(250);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_rv32ima_instruction_decoder_unit: PASS");
    end else begin
      $display("tb_rv32ima_instruction_decoder_unit: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb_rv32ima_instruction_decoder_unit: FAIL");
    $finish;
  end

endmodule
